// ===== rtl/core/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// Types and constants shared by the ray/rectangle intersection core.
// ----------------------------------------------------------------------------
package rri_pkg;

	localparam int CW = 20;          // coordinate width
	localparam int CFG_W = 60;       // configuration register width
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER = 2'd0,
		REG_RIGHT  = 2'd1,
		REG_UP     = 2'd2,
		REG_NORMAL = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] origin_x;
		logic signed [CW-1:0] origin_y;
		logic signed [CW-1:0] origin_z;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
		logic signed [CW-1:0] dir_z;
	} ray_word_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
		logic signed [CW-1:0] hit_z;
	} hit_word_t;

endpackage

// ===== rtl/core/rri_div.sv =====
// ----------------------------------------------------------------------------
// rri_div
// Pipelined restoring divider: one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rri_div #(
	parameter int NW = 64,   // dividend width (unsigned)
	parameter int DW = 48,   // divisor width (unsigned)
	parameter int QW = 20,   // quotient bits kept (result saturates above)
	parameter int TW = 1     // side payload width
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [QW-1:0] lim,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] out_tag
);
	// Quotient bits above QW-1 only matter as overflow; detect overflow up front
	// by testing num >= den << QW, then run QW restoring steps.
	// Remainder stays below den, so one bit over the divisor width is enough.
	localparam int RW = DW + 1;

	logic          v_s   [QW+1];
	logic [QW-1:0] n_s   [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [QW-1:0] l_s   [QW+1];
	logic          ov_s  [QW+1];
	logic [TW-1:0] t_s   [QW+1];
	logic [RW-1:0] r_s   [QW+1];

	logic [NW+QW:0] big_d;
	logic [NW+QW:0] big_n;
	assign big_d = (NW+QW+1)'(den) << QW;
	assign big_n = {{(QW+1){1'b0}}, num};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		n_s[0]  <= num[QW-1:0];
		d_s[0]  <= den;
		q_s[0]  <= '0;
		l_s[0]  <= lim;
		t_s[0]  <= tag;
		ov_s[0] <= (big_n >= big_d);
		// remainder seeded with bits of num above QW (below den when no ov)
		r_s[0]  <= RW'(num >> QW);
	end

	genvar g;
	generate
		for (g = 0; g < QW; g++) begin : g_step
			logic [RW-1:0] rem;
			logic          ge;
			assign rem = {r_s[g][RW-2:0], n_s[g][QW-1-g]};
			assign ge  = rem >= {1'b0, d_s[g]};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g+1] <= 1'b0;
				end else begin
					v_s[g+1] <= v_s[g];
				end
			end
			always_ff @(posedge clk) begin
				n_s[g+1]  <= n_s[g];
				d_s[g+1]  <= d_s[g];
				l_s[g+1]  <= l_s[g];
				ov_s[g+1] <= ov_s[g];
				t_s[g+1]  <= t_s[g];
				r_s[g+1]  <= ge ? rem - {1'b0, d_s[g]} : rem;
				q_s[g+1]  <= {q_s[g][QW-2:0], ge};
			end
		end
	endgenerate

	assign out_valid = v_s[QW];
	assign out_tag   = t_s[QW];
	assign quo       = (ov_s[QW] || q_s[QW] > l_s[QW]) ? l_s[QW] : q_s[QW];
endmodule

// ===== rtl/core/ray_rectangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_rectangle_intersect
// Fixed-point ray versus configured rectangle test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - Pulse start with a ray word on ray; accepted when start & !busy.
//    busy is tied low: a new ray may enter every clock cycle.
//  - One result word per ray appears on result for one cycle with done high,
//    in ray order. The receiver cannot stall, so nothing backs up.
//  - Path from the accepting edge to the cycle with done high: product and
//    sum stages, the divider input register, a CW-step divider pipeline,
//    then t*dir, hit point, edge products, edge sums and the output
//    register. Throughput one ray per cycle.
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//    Index 0 corner, 1 right edge, 2 up edge, 3 plane normal, each three
//    CW-bit signed components, x lowest. Write only while no ray is
//    in flight.
//  - Reset clears every valid bit and the configuration registers only.
//  - Rays parallel to the plane and misses return hit = 0 and zero coords.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect #(
	parameter int FRAC_BITS  = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  rri_pkg::ray_word_t           ray,
	output logic                         done,
	output rri_pkg::hit_word_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [59:0]                  cfg_data
);
	import rri_pkg::*;

	localparam int C   = CW;
	localparam int PW  = 2*C + 4;            // dot-product width (signed)
	localparam int NW  = PW + FRAC_BITS;     // scaled numerator magnitude
	localparam int TPW = 2*C;                // t*dir product
	localparam int HW  = C + 2;              // hit - corner
	localparam int EW  = 2*HW + 4;           // edge dot width

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	logic [59:0] corner_q, right_q, up_q, normal_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			right_q  <= '0;
			up_q     <= '0;
			normal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CORNER: corner_q <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_UP:     up_q     <= cfg_data;
				REG_NORMAL: normal_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	function automatic logic signed [C-1:0] comp(input logic [59:0] r, input int k);
		logic [191:0] w;
		w = {132'd0, r};
		return w[k*C +: C];
	endfunction

	logic signed [C-1:0] cx, cy, cz, rx, ry, rz, ux, uy, uz, nx, ny, nz;
	assign cx = comp(corner_q, 0); assign cy = comp(corner_q, 1); assign cz = comp(corner_q, 2);
	assign rx = comp(right_q, 0);  assign ry = comp(right_q, 1);  assign rz = comp(right_q, 2);
	assign ux = comp(up_q, 0);     assign uy = comp(up_q, 1);     assign uz = comp(up_q, 2);
	assign nx = comp(normal_q, 0); assign ny = comp(normal_q, 1); assign nz = comp(normal_q, 2);

	logic in_fire;
	assign in_fire = start & ~busy;

	logic signed [C-1:0] ox, oy, oz, dx, dy, dz;
	assign ox = ray.origin_x[C-1:0]; assign oy = ray.origin_y[C-1:0];
	assign oz = ray.origin_z[C-1:0];
	assign dx = ray.dir_x[C-1:0]; assign dy = ray.dir_y[C-1:0]; assign dz = ray.dir_z[C-1:0];

	// s1: products
	logic v_s1;
	logic signed [C-1:0] ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] dn0_s1, dn1_s1, dn2_s1, nm0_s1, nm1_s1, nm2_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_fire;
	end
	always_ff @(posedge clk) begin
		ox_s1 <= ox; oy_s1 <= oy; oz_s1 <= oz;
		dx_s1 <= dx; dy_s1 <= dy; dz_s1 <= dz;
		dn0_s1 <= PW'(dx) * PW'(nx);
		dn1_s1 <= PW'(dy) * PW'(ny);
		dn2_s1 <= PW'(dz) * PW'(nz);
		nm0_s1 <= PW'((C+1)'(cx) - (C+1)'(ox)) * PW'(nx);
		nm1_s1 <= PW'((C+1)'(cy) - (C+1)'(oy)) * PW'(ny);
		nm2_s1 <= PW'((C+1)'(cz) - (C+1)'(oz)) * PW'(nz);
	end

	// s2: sums
	logic v_s2;
	logic signed [C-1:0] ox_s2, oy_s2, oz_s2, dx_s2, dy_s2, dz_s2;
	logic signed [PW-1:0] den_s2, num_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		ox_s2 <= ox_s1; oy_s2 <= oy_s1; oz_s2 <= oz_s1;
		dx_s2 <= dx_s1; dy_s2 <= dy_s1; dz_s2 <= dz_s1;
		den_s2 <= dn0_s1 + dn1_s1 + dn2_s1;
		num_s2 <= nm0_s1 + nm1_s1 + nm2_s1;
	end

	// magnitudes and sign into the divider
	logic [NW-1:0] nmag;
	logic [PW-1:0] dmag;
	logic          negq, par;
	logic [C-1:0]  lim;
	assign nmag = NW'(num_s2[PW-1] ? PW'(-num_s2) : PW'(num_s2)) << FRAC_BITS;
	assign dmag = den_s2[PW-1] ? PW'(-den_s2) : PW'(den_s2);
	assign negq = num_s2[PW-1] ^ den_s2[PW-1];
	assign par  = (den_s2 == '0);
	assign lim  = negq ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};

	localparam int TAGW = 6*C + 2;
	logic [TAGW-1:0] tag_in, tag_out;
	assign tag_in = {negq, par, ox_s2, oy_s2, oz_s2, dx_s2, dy_s2, dz_s2};

	logic          dv;
	logic [C-1:0]  tq;
	rri_div #(.NW(NW), .DW(PW), .QW(C), .TW(TAGW)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.num(nmag), .den(dmag | PW'(par)), .lim(lim), .tag(tag_in),
		.out_valid(dv), .quo(tq), .out_tag(tag_out)
	);

	logic negq_d, par_d;
	logic signed [C-1:0] ox_d, oy_d, oz_d, dx_d, dy_d, dz_d;
	assign {negq_d, par_d, ox_d, oy_d, oz_d, dx_d, dy_d, dz_d} = tag_out;

	logic signed [C:0] t_sig;
	assign t_sig = negq_d ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

	// s3: t * dir
	logic v_s3, par_s3;
	logic signed [C-1:0] ox_s3, oy_s3, oz_s3;
	logic signed [TPW:0] px_s3, py_s3, pz_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= dv;
	end
	always_ff @(posedge clk) begin
		par_s3 <= par_d;
		ox_s3 <= ox_d; oy_s3 <= oy_d; oz_s3 <= oz_d;
		px_s3 <= (TPW+1)'(t_sig) * (TPW+1)'(dx_d);
		py_s3 <= (TPW+1)'(t_sig) * (TPW+1)'(dy_d);
		pz_s3 <= (TPW+1)'(t_sig) * (TPW+1)'(dz_d);
	end

	// floor shift is an arithmetic right shift
	function automatic logic signed [C-1:0] sat_add(input logic signed [C-1:0] o,
	                                               input logic signed [TPW:0] p);
		logic signed [TPW+1:0] s;
		logic signed [TPW+1:0] hi, lo;
		s  = (TPW+2)'(o) + (TPW+2)'(p >>> FRAC_BITS);
		hi = (TPW+2)'({1'b0, {(C-1){1'b1}}});
		lo = -hi - 1;
		if (s > hi)      return hi[C-1:0];
		else if (s < lo) return lo[C-1:0];
		else             return s[C-1:0];
	endfunction

	// s4: hit point and edge offset
	logic v_s4, par_s4;
	logic signed [C-1:0] hx_s4, hy_s4, hz_s4;
	logic signed [HW-1:0] ex_s4, ey_s4, ez_s4;
	logic signed [C-1:0] hx, hy, hz;
	assign hx = sat_add(ox_s3, px_s3);
	assign hy = sat_add(oy_s3, py_s3);
	assign hz = sat_add(oz_s3, pz_s3);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		par_s4 <= par_s3;
		hx_s4 <= hx; hy_s4 <= hy; hz_s4 <= hz;
		ex_s4 <= HW'(hx) - HW'(cx);
		ey_s4 <= HW'(hy) - HW'(cy);
		ez_s4 <= HW'(hz) - HW'(cz);
	end

	// s5: edge products
	logic v_s5, par_s5;
	logic signed [C-1:0] hx_s5, hy_s5, hz_s5;
	logic signed [EW-1:0] pr_s5 [3], pu_s5 [3], rr_s5 [3], uu_s5 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		par_s5 <= par_s4;
		hx_s5 <= hx_s4; hy_s5 <= hy_s4; hz_s5 <= hz_s4;
		pr_s5[0] <= EW'(ex_s4) * EW'(rx);
		pr_s5[1] <= EW'(ey_s4) * EW'(ry);
		pr_s5[2] <= EW'(ez_s4) * EW'(rz);
		pu_s5[0] <= EW'(ex_s4) * EW'(ux);
		pu_s5[1] <= EW'(ey_s4) * EW'(uy);
		pu_s5[2] <= EW'(ez_s4) * EW'(uz);
		rr_s5[0] <= EW'(rx) * EW'(rx);
		rr_s5[1] <= EW'(ry) * EW'(ry);
		rr_s5[2] <= EW'(rz) * EW'(rz);
		uu_s5[0] <= EW'(ux) * EW'(ux);
		uu_s5[1] <= EW'(uy) * EW'(uy);
		uu_s5[2] <= EW'(uz) * EW'(uz);
	end

	// s6: sums
	logic v_s6, par_s6;
	logic signed [C-1:0] hx_s6, hy_s6, hz_s6;
	logic signed [EW-1:0] dr_s6, du_s6, lr_s6, lu_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		par_s6 <= par_s5;
		hx_s6 <= hx_s5; hy_s6 <= hy_s5; hz_s6 <= hz_s5;
		dr_s6 <= pr_s5[0] + pr_s5[1] + pr_s5[2];
		du_s6 <= pu_s5[0] + pu_s5[1] + pu_s5[2];
		lr_s6 <= rr_s5[0] + rr_s5[1] + rr_s5[2];
		lu_s6 <= uu_s5[0] + uu_s5[1] + uu_s5[2];
	end

	// s7: compare and output word
	logic is_hit;
	assign is_hit = !par_s6 && (dr_s6 > 0) && (dr_s6 < lr_s6) && (du_s6 > 0) && (du_s6 < lu_s6);

	logic      v_s7;
	hit_word_t res_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		res_s7.hit   <= is_hit;
		res_s7.hit_x <= is_hit ? CW'(hx_s6) : '0;
		res_s7.hit_y <= is_hit ? CW'(hy_s6) : '0;
		res_s7.hit_z <= is_hit ? CW'(hz_s6) : '0;
	end

	assign done   = v_s7;
	assign result = res_s7;

`ifndef ASSERT_OFF
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0)
		else $error("miss word carries nonzero point");
	a_par_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && par_s6 |=> !result.hit)
		else $error("parallel ray reported as hit");
	a_div_flow: assert property (@(posedge clk) disable iff (!arst_n)
		dv |-> ##5 done)
		else $error("divider output lost in back end");
`endif
endmodule
